/* hdl/interlaced_row_shifter_defines.svh */
// assertion macros for the interlaced row shifter
// no dependencies; included by the modules that carry assertions
`ifndef INTERLACED_ROW_SHIFTER_DEFINES_SVH
`define INTERLACED_ROW_SHIFTER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define IRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define IRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/irs_pkg.sv */
// shared constants and types for the interlaced row shifter
// no dependencies
`timescale 1ns / 1ps

package irs_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_PIXEL_BITS = 32;

    localparam int CFG_W   = 13;   // width of every config register
    localparam int PIX_W   = 32;   // pixel field width on the ports
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [CFG_W-1:0] RST_ROW_WIDTH = 13'd720;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        REG_ROW_WIDTH = 2'd0,
        REG_OFF_EVEN  = 2'd1,
        REG_OFF_ODD   = 2'd2
    } t_reg_idx;

endpackage

/* hdl/interlaced_row_shifter.sv */
// interlaced row shifter: two-bank row store with shifted read-back
// depends on irs_pkg and interlaced_row_shifter_defines.svh
`timescale 1ns / 1ps
`include "interlaced_row_shifter_defines.svh"

// Usage
//   input channel  (i_in_valid / o_in_stall): one pixel or drain word per cycle,
//     i_frame_start marks the first pixel of a frame, i_func high is a drain word
//   output channel (o_out_valid / i_out_stall): one shifted pixel of the previous
//     row for each accepted word once a full row is stored; o_row_end on its last
//   config via APB: row_width at 0x0, offset_even_rows at 0x4, offset_odd_rows at 0x8
// Throughput: one word per clock unless stalled; each word does one read and one
//   write in the row store, on opposite banks, so the single memory never blocks
// Pipeline: a result passes the memory read register, then the output register,
//   before it is presented
// Stall: the read register and the output register form a two-deep buffer;
//   o_in_stall rises only when both hold words and the receiver stalls
// Reset: control state clears, row_width goes to 720 and both offsets to 0;
//   the row store is not cleared, so the first row after reset only fills it
//   and gives no output

module interlaced_row_shifter #(
    parameter int MAX_WIDTH  = irs_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = irs_pkg::DEF_PIXEL_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_func,
    input  logic [irs_pkg::PIX_W-1:0]   i_pixel_in,
    input  logic                        i_frame_start,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [irs_pkg::PIX_W-1:0]   o_pixel_out,
    output logic                        o_row_end,
    // config port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [irs_pkg::ADDR_W-1:0]  paddr,
    input  logic [irs_pkg::DATA_W-1:0]  pwdata,
    output logic [irs_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    import irs_pkg::*;

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DEPTH = 2 * (2 ** CW);
    localparam int SW    = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
    localparam logic [13:0] MaxW14 = 14'(MAX_WIDTH);

    // config registers
    logic        [CFG_W-1:0] r_row_width;
    logic signed [CFG_W-1:0] r_off_even;
    logic signed [CFG_W-1:0] r_off_odd;

    // control state
    logic [CW-1:0] r_col;
    logic          r_parity;
    logic          r_bank;
    logic          r_prev_valid;
    logic          r_prev_parity;

    // row store and read register
    logic [SW-1:0] r_row_store [DEPTH];
    logic [SW-1:0] r_mem_q;

    // read stage and output register
    logic              r_s1_valid;
    logic              r_s1_zero;
    logic              r_s1_last;
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_pixel;
    logic              r_out_row_end;

    logic                  cfg_wr;
    logic [1:0]            cfg_idx;
    logic                  in_acc;
    logic                  is_drain;
    logic                  ignore;
    logic                  fs;
    logic                  produce;
    logic [CW-1:0]         col_eff;
    logic                  parity_eff;
    logic [13:0]           eff_w;
    logic                  last;
    logic signed [CFG_W-1:0] sel_off;
    logic signed [14:0]    src;
    logic                  src_in;
    logic [CW:0]           raddr;
    logic [CW:0]           waddr;
    logic [SW-1:0]         wdata;
    logic                  s1_adv;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_comb begin
        unique case (cfg_idx)
            REG_ROW_WIDTH: prdata = {{(DATA_W-CFG_W){1'b0}}, r_row_width};
            REG_OFF_EVEN:  prdata = {{(DATA_W-CFG_W){1'b0}}, r_off_even};
            REG_OFF_ODD:   prdata = {{(DATA_W-CFG_W){1'b0}}, r_off_odd};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= RST_ROW_WIDTH;
            r_off_even  <= '0;
            r_off_odd   <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ROW_WIDTH: r_row_width <= pwdata[CFG_W-1:0];
                REG_OFF_EVEN:  r_off_even  <= pwdata[CFG_W-1:0];
                REG_OFF_ODD:   r_off_odd   <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // width in use: zero acts as one, clamp to MAX_WIDTH
    always_comb begin
        if (r_row_width == '0) begin
            eff_w = 14'd1;
        end else if ({1'b0, r_row_width} > MaxW14) begin
            eff_w = MaxW14;
        end else begin
            eff_w = {1'b0, r_row_width};
        end
    end

    assign o_in_stall = r_s1_valid && r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign is_drain   = (i_func == FUNC_DRAIN);
    assign ignore     = is_drain && !r_prev_valid;
    assign fs         = !is_drain && i_frame_start;
    assign produce    = r_prev_valid;

    assign col_eff    = fs ? '0 : r_col;
    assign parity_eff = fs ? 1'b0 : r_parity;
    assign last       = 14'(col_eff) >= (eff_w - 14'd1);

    // output column c takes source column c - offset
    assign sel_off = r_prev_parity ? r_off_odd : r_off_even;
    assign src     = $signed({1'b0, 14'(col_eff)}) - 15'(sel_off);
    assign src_in  = !src[14] && (src[13:0] < eff_w);

    assign raddr = {~r_bank, src[CW-1:0]};
    assign waddr = {r_bank, col_eff};
    assign wdata = is_drain ? '0 : SW'(i_pixel_in);

    always_ff @(posedge i_clk) begin
        if (in_acc && !ignore) begin
            r_row_store[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && produce) begin
            r_mem_q <= r_row_store[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col         <= '0;
            r_parity      <= 1'b0;
            r_bank        <= 1'b0;
            r_prev_valid  <= 1'b0;
            r_prev_parity <= 1'b0;
        end else if (in_acc && !ignore) begin
            if (last) begin
                r_col         <= '0;
                r_prev_parity <= parity_eff;
                r_parity      <= ~parity_eff;
                r_bank        <= ~r_bank;
                r_prev_valid  <= !is_drain;
            end else begin
                r_col    <= CW'(col_eff + 1'b1);
                r_parity <= parity_eff;
            end
        end
    end

    // read stage moves on whenever the output register is free or drains
    assign s1_adv = r_s1_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= produce;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_zero <= !src_in;
            r_s1_last <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_pixel   <= r_s1_zero ? '0 : PIX_W'(r_mem_q);
            r_out_row_end <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_out_pixel;
    assign o_row_end   = r_out_row_end;

    `IRS_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, o_in_stall,
        r_s1_valid && r_out_valid, "input stalled without a full buffer")
    `IRS_ASSERT_NEXT(a_no_prev_no_out, i_clk, i_rst_n, in_acc && !r_prev_valid,
        !r_s1_valid, "result issued with no stored row")
    `IRS_ASSERT_NEXT(a_s1_held, i_clk, i_rst_n, r_s1_valid && r_out_valid && i_out_stall,
        r_s1_valid && $stable(r_mem_q), "read stage lost while stalled")
    `IRS_ASSERT_NEXT(a_bank_swap, i_clk, i_rst_n, in_acc && !ignore && last,
        r_bank != $past(r_bank), "banks did not swap at row end")
    `IRS_ASSERT_NEXT(a_prev_after_pixel_row, i_clk, i_rst_n,
        in_acc && !is_drain && last, r_prev_valid, "finished row not marked valid")

endmodule

/* sim/tb_interlaced_row_shifter.sv */
// testbench for the interlaced row shifter: predicts shifted rows word by word,
// drives random raster traffic with stalls and gaps, and writes config over apb
// depends on irs_pkg and the interlaced_row_shifter rtl
`timescale 1ns / 1ps

module tb_interlaced_row_shifter;
    import irs_pkg::*;

    localparam int MAX_W          = DEF_MAX_WIDTH;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WORD_TARGET    = 1700;
    localparam int CALM_WORDS     = 250;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             last;
    } t_shifted_px;

    class row_shift_tracker;
        logic [PIX_W-1:0] line_mem [2*MAX_W];
        int               col_cnt;
        bit               parity;
        bit               wbank;
        bit               prev_ok;
        bit               prev_parity;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] off_even;
        logic [CFG_W-1:0] off_odd;
        t_shifted_px      shifted_q[$];
        int               errors;

        function new();
            foreach (line_mem[k]) line_mem[k] = '0;
            width_reg = RST_ROW_WIDTH;
            off_even  = '0;
            off_odd   = '0;
            col_cnt   = 0;
            errors    = 0;
        endfunction

        function void set_reg(input t_reg_idx idx, input logic [CFG_W-1:0] v);
            case (idx)
                REG_ROW_WIDTH: width_reg = v;
                REG_OFF_EVEN:  off_even  = v;
                REG_OFF_ODD:   off_odd   = v;
                default: ;
            endcase
        endfunction

        function int eff_width(input logic [CFG_W-1:0] r);
            int w;
            w = int'(r);
            if (w == 0) w = 1;
            if (w > MAX_W) w = MAX_W;
            return w;
        endfunction

        function int pending();
            return shifted_q.size();
        endfunction

        // one accepted word: emit the previous row's pixel landing at this column
        function void take_word(input logic f, input logic [PIX_W-1:0] p, input logic fs);
            int          w;
            int          c;
            int          off;
            int          src;
            bit          last;
            t_shifted_px e;
            if (f == FUNC_DRAIN && !prev_ok) return;
            if (f == FUNC_PIXEL && fs) begin
                col_cnt = 0;
                parity  = 1'b0;
            end
            w = eff_width(width_reg);
            c = (col_cnt >= MAX_W) ? MAX_W - 1 : col_cnt;
            last = (c >= w - 1);
            if (prev_ok) begin
                off = prev_parity ? int'($signed(off_odd)) : int'($signed(off_even));
                src = c - off;
                e.pix  = (src >= 0 && src < w) ? line_mem[(wbank ? 0 : MAX_W) + src] : '0;
                e.last = last;
                shifted_q.push_back(e);
            end
            line_mem[(wbank ? MAX_W : 0) + c] = (f == FUNC_DRAIN) ? '0 : p;
            if (last) begin
                col_cnt     = 0;
                prev_parity = parity;
                parity      = ~parity;
                wbank       = ~wbank;
                prev_ok     = (f != FUNC_DRAIN);
            end else begin
                col_cnt = c + 1;
            end
        endfunction

        function void check_pixel(input logic [PIX_W-1:0] p, input logic re);
            t_shifted_px e;
            if (shifted_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual pixel %h row_end %b",
                         $time, p, re);
                errors++;
                return;
            end
            e = shifted_q.pop_front();
            if (p !== e.pix) begin
                $display("%0t: pixel_out expected %h actual %h", $time, e.pix, p);
                errors++;
            end
            if (re !== e.last) begin
                $display("%0t: row_end expected %b actual %b", $time, e.last, re);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               i_func        = FUNC_PIXEL;
    logic [PIX_W-1:0]   i_pixel_in    = '0;
    logic               i_frame_start = 1'b0;
    logic               i_out_stall   = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [ADDR_W-1:0]  paddr         = '0;
    logic [DATA_W-1:0]  pwdata        = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [PIX_W-1:0]   o_pixel_out;
    logic               o_row_end;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    row_shift_tracker tracker = new();
    bit               jitter;
    int               word_count;
    int               stall_hold;
    int               quiet_cycles;

    interlaced_row_shifter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_pixel_in    (i_pixel_in),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_out   (o_pixel_out),
        .o_row_end     (o_row_end),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver: random stall bursts while jitter is on
    always @(posedge i_clk) begin
        if (!i_rst_n || !jitter) begin
            stall_hold  <= 0;
            i_out_stall <= 1'b0;
        end else if (stall_hold > 0) begin
            stall_hold  <= stall_hold - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_hold  <= $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_pixel(o_pixel_out, o_row_end);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_width();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return CFG_W'(1);
            2:       return CFG_W'(2);
            default: return CFG_W'($urandom_range(3, 40));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_offset(input int w);
        int v;
        case ($urandom_range(0, 9))
            0:       v = 4095;
            1:       v = -4095;
            2:       v = -4096;
            3:       v = 0;
            4:       v = w;
            5:       v = -w;
            default: v = int'($urandom_range(0, 2 * w + 2)) - (w + 1);
        endcase
        return CFG_W'(v);
    endfunction

    task automatic push_word(input logic f, input logic [PIX_W-1:0] p, input logic fs);
        if (jitter && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= f;
        i_pixel_in    <= p;
        i_frame_start <= fs;
        do @(posedge i_clk); while (o_in_stall);
        if (f == FUNC_PIXEL || tracker.prev_ok) word_count++;
        tracker.take_word(f, p, fs);
    endtask

    // noisy rows get the odd restart mid-row and stray drain words
    task automatic send_row(input int n, input bit fs_first, input bit noisy);
        int   k;
        logic fs;
        for (k = 0; k < n; k++) begin
            fs = (k == 0) && fs_first;
            if (noisy && $urandom_range(0, 60) == 0) fs = 1'b1;
            if (noisy && $urandom_range(0, 80) == 0)
                push_word(FUNC_DRAIN, pick_pixel(), 1'($urandom_range(0, 1)));
            push_word(FUNC_PIXEL, pick_pixel(), fs);
        end
    endtask

    task automatic flush_row();
        while (tracker.prev_ok)
            push_word(FUNC_DRAIN, pick_pixel(), 1'($urandom_range(0, 1)));
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // words that give no result may still be in the pipe
    task automatic quiesce();
        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [CFG_W-1:0] v);
        logic [DATA_W-1:0] wd;
        if (idx == REG_ROW_WIDTH) wd = {{(DATA_W - CFG_W){1'b0}}, v};
        else wd = {{(DATA_W - CFG_W){v[CFG_W-1]}}, v};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wd;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_reg(idx, v);
        @(posedge i_clk);
    endtask

    // a wider row would read store columns the stored row never wrote: push it out first
    task automatic retune(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] oe,
                          input logic [CFG_W-1:0] oo);
        if (tracker.eff_width(w) > tracker.eff_width(tracker.width_reg)) flush_row();
        quiesce();
        apb_write(REG_ROW_WIDTH, w);
        apb_write(REG_OFF_EVEN, oe);
        apb_write(REG_OFF_ODD, oo);
    endtask

    initial begin
        int               phase;
        int               rows;
        int               r;
        int               w_eff;
        logic [CFG_W-1:0] w;

        jitter = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // three-pixel rows, even rows right by one, odd rows left by one
        retune(CFG_W'(3), CFG_W'(1), CFG_W'(-1));
        push_word(FUNC_DRAIN, pick_pixel(), 1'b1);
        push_word(FUNC_PIXEL, '0, 1'b1);
        push_word(FUNC_PIXEL, '1, 1'b0);
        push_word(FUNC_PIXEL, pick_pixel(), 1'b0);
        send_row(3, 1'b0, 1'b0);
        // restart mid-row: the stored row replays from column zero
        push_word(FUNC_PIXEL, pick_pixel(), 1'b0);
        send_row(3, 1'b1, 1'b0);
        flush_row();

        // width lowered while column four is next
        retune(CFG_W'(6), CFG_W'(0), CFG_W'(-2));
        send_row(4, 1'b1, 1'b0);
        quiesce();
        apb_write(REG_ROW_WIDTH, CFG_W'(2));
        send_row(2, 1'b0, 1'b0);
        flush_row();

        // zero width acts as one: every word is a row
        retune('0, '0, CFG_W'(4095));
        send_row(4, 1'b1, 1'b0);
        flush_row();

        phase = 0;
        while (word_count < WORD_TARGET) begin
            if (phase == 4) begin
                // width above the store clamps, then is lowered mid-row; extreme offsets
                retune(CFG_W'(8191), CFG_W'(4095), CFG_W'(-4095));
                send_row(8, 1'b1, 1'b0);
                quiesce();
                apb_write(REG_ROW_WIDTH, CFG_W'(3));
                send_row(4, 1'b0, 1'b0);
                flush_row();
            end
            w = pick_width();
            w_eff = tracker.eff_width(w);
            retune(w, pick_offset(w_eff), pick_offset(w_eff));
            rows = $urandom_range(1, 6);
            for (r = 0; r < rows; r++) begin
                jitter = (word_count < WORD_TARGET - CALM_WORDS) && ($urandom_range(0, 3) != 0);
                send_row(w_eff, (r == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 4) == 0),
                         1'b1);
                if ($urandom_range(0, 7) == 0) settle();
            end
            if ($urandom_range(0, 3) == 0) send_row($urandom_range(1, w_eff), 1'b0, 1'b1);
            if ($urandom_range(0, 2) == 0) flush_row();
            phase++;
        end

        jitter = 1'b0;
        flush_row();
        settle();
        repeat (SETTLE_CYCLES + 4) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* interlaced_row_shifter.f */
+incdir+hdl
hdl/irs_pkg.sv
hdl/interlaced_row_shifter.sv
sim/tb_interlaced_row_shifter.sv
